// ===== rtl/core/lrp_pkg.sv =====
// Package for the LRU replacement block with pinning.
// Holds sizes, operation and status codes and the sequencer state type.
// No dependencies.
package lrp_pkg;

    // Number of buffer slots tracked and the derived widths.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int PIN_W  = 16;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TOUCH  = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_PRESENCE = 2'd3;

    localparam t_cnt CAP_RESET = t_cnt'(16);

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic req_valid;
        logic go_scan;
        logic scan_end;
        logic out_free;
    } t_seq_stat;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
    } t_seq_ctl;

endpackage

// ===== rtl/core/lrp_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on lrp_pkg.
interface lrp_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    lrp_pkg::t_slot           slot;
    logic [lrp_pkg::PIN_W-1:0] pinned_mask;

    modport source (output valid, output operation, output slot, output pinned_mask,
                    input ready);
    modport sink   (input valid, input operation, input slot, input pinned_mask,
                    output ready);
endinterface

interface lrp_rsp_if;
    logic           valid;
    logic           ready;
    lrp_pkg::t_slot victim_slot;
    logic           victim_valid;
    logic [1:0]     status;
    logic           is_empty;
    lrp_pkg::t_cnt  occupancy;

    modport source (output valid, output victim_slot, output victim_valid,
                    output status, output is_empty, output occupancy, input ready);
    modport sink   (input valid, input victim_slot, input victim_valid,
                    input status, input is_empty, input occupancy, output ready);
endinterface

// ===== rtl/core/lru_replacement_with_pinning.sv =====
// Top level of the LRU replacement block with pinning: datapath and recency order.
// Depends on lrp_pkg, lrp_if, lrp_match and lrp_seq.
//
// The block keeps a least-to-most recent order of up to 16 buffer slots and answers
// each request with exactly one response. Requests are taken one at a time. An insert,
// or any request that needs no walk, goes from the transfer straight to the FINISH
// state, where its response is committed to the output register once that register is
// free, and the next request is taken back in IDLE. A touch of a held slot and every
// evict walk the recency order in the SCAN state one entry per cycle through a single
// shared compare unit, then go on to FINISH. A finished response sits in an output
// register, so the next request is accepted while it waits; a request that finishes
// while that register is still full holds until the response is taken. The capacity
// register may be written at any idle time; a lowered capacity keeps the held slots
// and refuses inserts until evicts bring occupancy below it. No clearing pass is
// needed after reset.
module lru_replacement_with_pinning (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  lrp_pkg::t_cnt     i_cfg_wr_data,
    lrp_req_if.sink           i_req,
    lrp_rsp_if.source         o_rsp
);

    // Recency order, index 0 is least recent; no reset.
    lrp_pkg::t_slot r_order [lrp_pkg::SLOTS];

    logic [lrp_pkg::SLOTS-1:0] r_resident;
    logic [lrp_pkg::SLOTS-1:0] n_resident;
    lrp_pkg::t_cnt             r_held;
    lrp_pkg::t_cnt             n_held;
    lrp_pkg::t_cnt             r_cap;

    // Captured request.
    logic [1:0]                r_op;
    lrp_pkg::t_slot            r_slot;
    logic [lrp_pkg::PIN_W-1:0] r_pins;
    lrp_pkg::t_cnt             r_ptr;
    logic                      r_found;
    lrp_pkg::t_slot            r_victim;

    // Output register.
    logic           r_out_valid;
    lrp_pkg::t_slot r_out_victim;
    logic           r_out_vvalid;
    logic [1:0]     r_out_status;
    logic           r_out_empty;
    lrp_pkg::t_cnt  r_out_occ;

    lrp_pkg::t_seq_stat seq_stat;
    lrp_pkg::t_seq_ctl  seq_ctl;
    lrp_pkg::t_state    seq_state;

    lrp_pkg::t_slot entry;
    logic           entry_match;
    logic           req_xfer;
    logic           out_free;
    lrp_pkg::t_cnt  limit;

    logic           wr_en;
    lrp_pkg::t_slot wr_addr;
    lrp_pkg::t_slot wr_data;

    logic           f_vvalid;
    lrp_pkg::t_slot f_victim;
    logic [1:0]     f_status;

    assign req_xfer = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign entry    = r_order[r_ptr[lrp_pkg::SLOT_W-1:0]];
    assign limit    = (r_cap < lrp_pkg::t_cnt'(lrp_pkg::SLOTS)) ? r_cap
                                                               : lrp_pkg::t_cnt'(lrp_pkg::SLOTS);

    // Sequencer status: touch of a held slot and every evict walk the order.
    assign seq_stat.req_valid = i_req.valid;
    assign seq_stat.go_scan   = (i_req.operation == lrp_pkg::OP_EVICT) ||
                                ((i_req.operation == lrp_pkg::OP_TOUCH) &&
                                 r_resident[i_req.slot]);
    assign seq_stat.scan_end  = (r_ptr == r_held);
    assign seq_stat.out_free  = out_free;

    lrp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_ctl   (seq_ctl),
        .o_state (seq_state)
    );

    lrp_match u_match (
        .i_entry    (entry),
        .i_slot     (r_slot),
        .i_pins     (r_pins),
        .i_is_touch (r_op == lrp_pkg::OP_TOUCH),
        .o_match    (entry_match)
    );

    assign i_req.ready = seq_ctl.accept;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lrp_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Request capture and scan progress.
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_op     <= i_req.operation;
            r_slot   <= i_req.slot;
            r_pins   <= i_req.pinned_mask;
            r_ptr    <= '0;
            r_found  <= 1'b0;
            r_victim <= '0;
        end else if (seq_ctl.scan_step) begin
            r_ptr <= r_ptr + lrp_pkg::t_cnt'(1);
            if (!r_found && entry_match) begin
                r_found  <= 1'b1;
                r_victim <= entry;
            end
        end
    end

    // Finish step: decide the response and the state update.
    always_comb begin
        n_held     = r_held;
        n_resident = r_resident;
        f_vvalid   = 1'b0;
        f_victim   = '0;
        f_status   = lrp_pkg::ST_OK;
        case (r_op)
            lrp_pkg::OP_INSERT: begin
                if (r_resident[r_slot]) begin
                    f_status = lrp_pkg::ST_PRESENCE;
                end else if (r_held >= limit) begin
                    f_status = lrp_pkg::ST_FULL;
                end else begin
                    n_held             = r_held + lrp_pkg::t_cnt'(1);
                    n_resident[r_slot] = 1'b1;
                end
            end
            lrp_pkg::OP_TOUCH: begin
                if (!r_resident[r_slot]) begin
                    f_status = lrp_pkg::ST_PRESENCE;
                end
            end
            lrp_pkg::OP_EVICT: begin
                if (r_found) begin
                    n_held               = r_held - lrp_pkg::t_cnt'(1);
                    n_resident[r_victim] = 1'b0;
                    f_vvalid             = 1'b1;
                    f_victim             = r_victim;
                end else begin
                    f_status = lrp_pkg::ST_NONE;
                end
            end
            default: f_status = lrp_pkg::ST_OK;
        endcase
    end

    // Single write port into the recency order.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = entry;
        if (seq_ctl.scan_step) begin
            // Entries behind the removed one move one place toward the old end.
            wr_en   = r_found;
            wr_addr = lrp_pkg::SLOT_W'(r_ptr - lrp_pkg::t_cnt'(1));
            wr_data = entry;
        end else if (seq_ctl.commit) begin
            if (r_op == lrp_pkg::OP_INSERT) begin
                wr_en   = (f_status == lrp_pkg::ST_OK);
                wr_addr = r_held[lrp_pkg::SLOT_W-1:0];
                wr_data = r_slot;
            end else if (r_op == lrp_pkg::OP_TOUCH) begin
                wr_en   = (f_status == lrp_pkg::ST_OK);
                wr_addr = lrp_pkg::SLOT_W'(r_held - lrp_pkg::t_cnt'(1));
                wr_data = r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_order[wr_addr] <= wr_data;
        end
    end

    // Held slot bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_resident <= '0;
        end else if (seq_ctl.commit) begin
            r_held     <= n_held;
            r_resident <= n_resident;
        end
    end

    // Response register, loaded on commit and freed on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctl.commit) begin
            r_out_victim <= f_victim;
            r_out_vvalid <= f_vvalid;
            r_out_status <= f_status;
            r_out_empty  <= (n_held == '0);
            r_out_occ    <= n_held;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.victim_slot  = r_out_victim;
    assign o_rsp.victim_valid = r_out_vvalid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.is_empty     = r_out_empty;
    assign o_rsp.occupancy    = r_out_occ;

    // The count of held slots matches the resident bits.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lrp_pkg::t_cnt'($countones(r_resident)) == r_held)
        else $error("held count and resident bits disagree");

    // The scan pointer never runs past the held entries.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_state == lrp_pkg::S_SCAN) |-> (r_ptr <= r_held))
        else $error("scan pointer beyond held entries");

    // A removed victim always comes with an ok status and was resident before.
    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctl.commit && f_vvalid) |-> (f_status == lrp_pkg::ST_OK && r_resident[r_victim]))
        else $error("victim reported without ok status or not resident");

    // A commit never drops a response that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !seq_ctl.commit)
        else $error("response register overwritten");

    // Occupancy never exceeds the slot count.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.commit |=> (r_held <= lrp_pkg::t_cnt'(lrp_pkg::SLOTS)))
        else $error("occupancy above slot count");

endmodule

// ===== rtl/core/lrp_match.sv =====
// Shared compare unit used by every scan step over the recency order.
// Depends on lrp_pkg.
module lrp_match (
    input  lrp_pkg::t_slot            i_entry,
    input  lrp_pkg::t_slot            i_slot,
    input  logic [lrp_pkg::PIN_W-1:0] i_pins,
    input  logic                      i_is_touch,
    output logic                      o_match
);

    // Touch looks for its own slot; evict looks for the first unpinned entry.
    always_comb begin
        if (i_is_touch) begin
            o_match = (i_entry == i_slot);
        end else begin
            o_match = !i_pins[i_entry];
        end
    end

endmodule

// ===== rtl/core/lrp_seq.sv =====
// Sequencer that steps one request through accept, scan and finish.
// Depends on lrp_pkg.
module lrp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrp_pkg::t_seq_stat i_stat,
    output lrp_pkg::t_seq_ctl  o_ctl,
    output lrp_pkg::t_state    o_state
);

    lrp_pkg::t_state r_state;
    lrp_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrp_pkg::S_IDLE: begin
                if (i_stat.req_valid) begin
                    n_state = i_stat.go_scan ? lrp_pkg::S_SCAN : lrp_pkg::S_FINISH;
                end
            end
            lrp_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = lrp_pkg::S_FINISH;
                end
            end
            lrp_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = lrp_pkg::S_IDLE;
                end
            end
            default: n_state = lrp_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ctl = '0;
        case (r_state)
            lrp_pkg::S_IDLE:   o_ctl.accept    = 1'b1;
            lrp_pkg::S_SCAN:   o_ctl.scan_step = !i_stat.scan_end;
            lrp_pkg::S_FINISH: o_ctl.commit    = i_stat.out_free;
            default:           o_ctl           = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

// ===== test/lru_replacement_with_pinning_tb.sv =====
`timescale 1ns / 100ps
// Testbench for lru_replacement_with_pinning: insert, touch, evict and no-op requests with
// random idling on both channels, each response checked against a recency-order predictor.
// Depends on lrp_pkg and the lrp_req_if / lrp_rsp_if interfaces.
module lru_replacement_with_pinning_tb;
    import lrp_pkg::*;

    // Operation code 3 is accepted and answered but does nothing.
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int IDLE_LIMIT       = 4000;
    localparam int SETTLE_CYCLES    = 25;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 550;
    localparam int PHASES           = 10;
    localparam int MAX_PRINTED      = 60;

    typedef logic [PIN_W-1:0] t_mask;

    // One response as seen on the output channel.
    typedef struct packed {
        t_slot      victim_slot;
        logic       victim_valid;
        logic [1:0] status;
        logic       is_empty;
        t_cnt       occupancy;
    } t_outcome;

    // Recency-order predictor and the queue of responses it still expects.
    class recency_scoreboard;
        t_slot       order[SLOTS];
        logic [SLOTS-1:0] held_mask;
        int          held;
        t_cnt        cap;
        t_outcome    due_q[$];
        int          errors;
        int          checked;

        function new();
            held      = 0;
            held_mask = '0;
            cap       = CAP_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_capacity(t_cnt value);
            cap = value;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Remove one entry and close the gap toward the least recent end.
        function void drop_at(int pos);
            for (int i = pos; i < held - 1; i++) order[i] = order[i + 1];
            held--;
        endfunction

        // Apply one accepted request to the predicted state and queue its response.
        function void note_request(logic [1:0] op, t_slot s, t_mask pins);
            t_outcome res;
            int limit;
            res   = '0;
            limit = (int'(cap) < SLOTS) ? int'(cap) : SLOTS;
            case (op)
                OP_INSERT: begin
                    // A resident slot is reported before the full check.
                    if (held_mask[s]) begin
                        res.status = ST_PRESENCE;
                    end else if (held >= limit) begin
                        res.status = ST_FULL;
                    end else begin
                        order[held]  = s;
                        held++;
                        held_mask[s] = 1'b1;
                    end
                end
                OP_TOUCH: begin
                    if (!held_mask[s]) begin
                        res.status = ST_PRESENCE;
                    end else begin
                        for (int i = 0; i < held; i++) begin
                            if (order[i] == s) begin
                                drop_at(i);
                                break;
                            end
                        end
                        order[held] = s;
                        held++;
                    end
                end
                OP_EVICT: begin
                    // Walk from the least recent end, skipping pinned slots.
                    res.status = ST_NONE;
                    for (int i = 0; i < held; i++) begin
                        if (!pins[order[i]]) begin
                            res.victim_slot       = order[i];
                            res.victim_valid      = 1'b1;
                            res.status            = ST_OK;
                            held_mask[order[i]]   = 1'b0;
                            drop_at(i);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            res.is_empty  = (held == 0);
            res.occupancy = t_cnt'(held);
            due_q.push_back(res);
        endfunction

        // Print a bounded number of lines but count every mismatch.
        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("response %0d: %s is %0h, expected %0h",
                                 checked, name, got, want));
        endtask

        // Compare one transferred response with the oldest expectation.
        task check_response(t_outcome got);
            t_outcome want;
            if (due_q.size() == 0) begin
                report($sformatf("response with nothing outstanding, status %0d", got.status));
            end else begin
                want = due_q.pop_front();
                compare_field("victim_slot", 8'(got.victim_slot), 8'(want.victim_slot));
                compare_field("victim_valid", 8'(got.victim_valid), 8'(want.victim_valid));
                compare_field("status", 8'(got.status), 8'(want.status));
                compare_field("is_empty", 8'(got.is_empty), 8'(want.is_empty));
                compare_field("occupancy", 8'(got.occupancy), 8'(want.occupancy));
            end
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    t_cnt cfg_wr_data;

    lrp_req_if req_ch();
    lrp_rsp_if rsp_ch();

    recency_scoreboard lru_board = new();
    bit hold_request = 1'b0;
    int idle_cycles;

    lru_replacement_with_pinning DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Response side: check each transfer and drive ready with its own stall pattern.
    initial begin : response_side
        int hold_left;
        int mode_left;
        int rx_mode;
        t_outcome got;
        hold_left    = 0;
        mode_left    = 0;
        rx_mode      = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.victim_slot  = rsp_ch.victim_slot;
                got.victim_valid = rsp_ch.victim_valid;
                got.status       = rsp_ch.status;
                got.is_empty     = rsp_ch.is_empty;
                got.occupancy    = rsp_ch.occupancy;
                lru_board.check_response(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either channel for too long.
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("lru_replacement_with_pinning_tb failed");
        $finish;
    end

    // Offer one request and hold it until the transfer; valid stays high afterward.
    task automatic send_req(logic [1:0] op, t_slot s, t_mask pins);
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.slot        <= s;
        req_ch.pinned_mask <= pins;
        do @(posedge i_clk); while (!req_ch.ready);
        lru_board.note_request(op, s, pins);
    endtask

    task automatic pause_req(int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (lru_board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(t_cnt value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        lru_board.set_capacity(value);
    endtask

    // Random request, steered so that most inserts and touches do real work.
    function automatic void pick_item(output logic [1:0] op, output t_slot s,
                                      output t_mask pins);
        int roll;
        t_slot cand[$];
        roll = $urandom_range(0, 99);
        s    = t_slot'($urandom_range(0, SLOTS - 1));
        pins = t_mask'($urandom);
        if (roll < 40)
            op = OP_INSERT;
        else if (roll < 65)
            op = OP_TOUCH;
        else if (roll < 94)
            op = OP_EVICT;
        else
            op = OP_NOP;
        if ((op == OP_INSERT || op == OP_TOUCH) && $urandom_range(0, 3) != 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (lru_board.held_mask[i] == (op == OP_TOUCH)) cand.push_back(t_slot'(i));
            if (cand.size() > 0) s = cand[$urandom_range(0, cand.size() - 1)];
        end
        if (op == OP_EVICT) begin
            case ($urandom_range(0, 3))
                0: pins = '0;
                1: pins = t_mask'($urandom) & t_mask'($urandom);
                // Every held slot pinned, so nothing can be evicted.
                2: pins = lru_board.held_mask | t_mask'($urandom);
                default: ;
            endcase
        end
    endfunction

    // Main sequence: reset, directed cases, then random phases at several capacities.
    initial begin : stimulus
        logic [1:0] op;
        t_slot s;
        t_mask pins;
        t_cnt cap;
        int per_phase;
        int sent;
        int burst;
        bit paused;
        i_rst_n            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = CAP_RESET;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_INSERT;
        req_ch.slot        = '0;
        req_ch.pinned_mask = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty order, absent slot, resident slot and pinning at the default capacity.
        send_req(OP_EVICT, 4'd0, '0);
        send_req(OP_TOUCH, 4'd5, '0);
        send_req(OP_INSERT, 4'd0, '0);
        send_req(OP_INSERT, 4'd15, 16'hFFFF);
        send_req(OP_INSERT, 4'd0, '0);
        send_req(OP_TOUCH, 4'd0, '0);
        send_req(OP_EVICT, 4'd0, 16'h8000);
        send_req(OP_INSERT, 4'd7, '0);
        send_req(OP_EVICT, 4'd0, 16'hFFFF);
        send_req(OP_NOP, 4'd9, 16'h5A5A);

        // Capacity lowered below the occupancy: inserts refused until evicts catch up.
        write_capacity(t_cnt'(1));
        send_req(OP_INSERT, 4'd3, '0);
        send_req(OP_EVICT, 4'd0, '0);
        send_req(OP_INSERT, 4'd3, '0);
        send_req(OP_EVICT, 4'd0, '0);
        send_req(OP_INSERT, 4'd3, '0);

        // Capacity zero: absent slots are full, resident ones still report presence.
        write_capacity(t_cnt'(0));
        send_req(OP_INSERT, 4'd4, '0);
        send_req(OP_INSERT, 4'd3, '0);
        send_req(OP_TOUCH, 4'd3, '0);

        // Capacity above the slot count acts as the slot count.
        write_capacity(t_cnt'(31));
        send_req(OP_INSERT, 4'd4, '0);
        send_req(OP_INSERT, 4'd9, '0);
        send_req(OP_TOUCH, 4'd3, 16'hFFFF);
        send_req(OP_EVICT, 4'd15, 16'h0210);
        send_req(OP_NOP, 4'd0, '0);

        // Random phases in bursts with gaps between them.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: cap = t_cnt'(16);
                1: cap = t_cnt'(31);
                2: cap = t_cnt'(3);
                3: cap = t_cnt'(0);
                4: cap = t_cnt'(1);
                default: cap = ($urandom_range(0, 9) == 0) ? t_cnt'($urandom_range(17, 31))
                                                           : t_cnt'($urandom_range(2, 16));
            endcase
            write_capacity(cap);
            sent   = 0;
            paused = 1'b0;
            while (sent < per_phase) begin
                burst = $urandom_range(1, 20);
                // The receiver holds off while a long burst backs up the block.
                if (ph == 5 && sent == 0) begin
                    hold_request = 1'b1;
                    burst        = 40;
                end
                for (int k = 0; k < burst && sent < per_phase; k++) begin
                    pick_item(op, s, pins);
                    send_req(op, s, pins);
                    sent++;
                end
                if (ph == 7 && !paused && sent >= per_phase / 2) begin
                    drain();
                    paused = 1'b1;
                end else begin
                    pause_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (lru_board.errors == 0 && lru_board.pending() == 0)
            $display("lru_replacement_with_pinning_tb passed");
        else
            $display("lru_replacement_with_pinning_tb failed");
        $finish;
    end

endmodule
